// File: hw/rtl/segment_near_clip_project_core_defines.svh
// Assertion macros used by the checker file.
`ifndef SEGMENT_NEAR_CLIP_PROJECT_CORE_DEFINES_SVH
`define SEGMENT_NEAR_CLIP_PROJECT_CORE_DEFINES_SVH

// Check a consequence in the same cycle.
`define SNC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snc check failed");

// Check a consequence in the next cycle.
`define SNC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snc check failed");

`endif

// File: hw/rtl/snc_pkg.sv
// Types and constants shared by the segment clip and projection block.
`timescale 1ns / 1ps
package snc_pkg;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam logic [1:0] REG_NEAR_DEPTH    = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam int NEAR_W   = 31;
    localparam int SCREEN_W = 13;
    localparam int OUT_W    = 16;
    localparam int QB       = 16;
    localparam int LANES    = 4;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;

    localparam logic [NEAR_W-1:0]   NEAR_RESET   = 31'd6554;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd600;

    localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic               vis;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } line_t;

    typedef struct packed {
        line_t              ln;
        logic               crossing;
        logic               a_out;
        logic signed [32:0] dx;
        logic signed [32:0] dz;
    } seg_t;

endpackage

// File: hw/rtl/segment_near_clip_project_core.sv
// Top level of the near-plane segment clip and perspective projection block.
// Input channel: one camera-space segment per beat (ax, ay, az, bx, by_depth, bz, signed Q16.16)
// on in_valid / in_ready. Output channel: one beat per segment on out_valid / out_ready with
// visible and four saturated 16-bit screen coordinates; an invisible segment gives zeros.
// Registers on the APB port: near_depth at 0x0, screen_width at 0x4, screen_height at 0x8.
// From input beat to output beat a segment passes the clip pipeline, whose restoring divider
// for t takes one bit a stage, then the queue, then the projection pipeline, whose four
// dividers take one quotient bit a stage. Throughput is one segment per cycle while the
// output is not stalled by out_ready.
// Reset empties both pipelines and the queue and loads near_depth 6554, width 800,
// height 600. When out_ready is low the projection pipeline holds, the queue fills,
// and the clip pipeline then holds and drops in_ready; no beat is lost or repeated.
`timescale 1ns / 1ps
module segment_near_clip_project_core #(
    parameter int FOCAL_LENGTH = 400,
    parameter int FRAC_BITS    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snc_pkg::ADDR_W-1:0]  paddr,
    input  logic [snc_pkg::DATA_W-1:0]  pwdata,
    output logic [snc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [31:0]          ax,
    input  logic signed [31:0]          ay,
    input  logic signed [31:0]          az,
    input  logic signed [31:0]          bx,
    input  logic signed [31:0]          by_depth,
    input  logic signed [31:0]          bz,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        visible,
    output logic signed [15:0]          screen_ax,
    output logic signed [15:0]          screen_ay,
    output logic signed [15:0]          screen_bx,
    output logic signed [15:0]          screen_by
);
    import snc_pkg::*;

    logic [NEAR_W-1:0]   near_depth_reg;
    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;
    logic [NEAR_W-1:0]   nd;
    logic                wr_en;
    logic                clip_valid;
    logic                clip_ready;
    line_t               clip_line;
    logic                q_valid;
    logic                q_ready;
    line_t               q_line;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign nd     = (near_depth_reg == '0) ? NEAR_W'(1) : near_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_depth_reg    <= NEAR_RESET;
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_NEAR_DEPTH:    near_depth_reg    <= pwdata[NEAR_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[SCREEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NEAR_DEPTH:    prdata = {1'b0, near_depth_reg};
            REG_SCREEN_WIDTH:  prdata = {19'd0, screen_width_reg};
            REG_SCREEN_HEIGHT: prdata = {19'd0, screen_height_reg};
            default:           prdata = '0;
        endcase
    end

    snc_clip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ax        (ax),
        .ay        (ay),
        .az        (az),
        .bx        (bx),
        .by_depth  (by_depth),
        .bz        (bz),
        .nd        (nd),
        .out_valid (clip_valid),
        .out_ready (clip_ready),
        .out_line  (clip_line)
    );

    snc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (clip_valid),
        .push_ready (clip_ready),
        .push_data  (clip_line),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_line)
    );

    snc_proj #(
        .FOCAL_LENGTH (FOCAL_LENGTH)
    ) u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_line   (q_line),
        .width     (screen_width_reg),
        .height    (screen_height_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .visible   (visible),
        .screen_ax (screen_ax),
        .screen_ay (screen_ay),
        .screen_bx (screen_bx),
        .screen_by (screen_by)
    );

endmodule

// File: hw/rtl/snc_clip.sv
// Front end: classify a segment against the near plane, divide for t, move the outside endpoint.
`timescale 1ns / 1ps
module snc_clip #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [31:0]          ax,
    input  logic signed [31:0]          ay,
    input  logic signed [31:0]          az,
    input  logic signed [31:0]          bx,
    input  logic signed [31:0]          by_depth,
    input  logic signed [31:0]          bz,
    input  logic [snc_pkg::NEAR_W-1:0]  nd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output snc_pkg::line_t              out_line
);
    import snc_pkg::*;

    localparam int DS = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 35;
    localparam int LAST = DS + 2;
    localparam logic [PW-1:0] RND = PW'((64'd1 << FRAC_BITS) - 64'd1);

    logic               vld_reg [0:LAST];
    seg_t               seg_reg [0:DS];
    logic [33:0]        rem_reg [0:DS];
    logic [33:0]        dvs_reg [0:DS];
    logic [TW-1:0]      t_reg   [0:DS];
    seg_t               l1_seg_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] pz_reg;
    line_t              l2_reg;

    seg_t               seg_next;
    logic [33:0]        rem_next [1:DS];
    logic [TW-1:0]      t_next   [1:DS];
    logic [33:0]        num_next;
    logic [33:0]        dvs_next;
    logic signed [PW-1:0] px_next;
    logic signed [PW-1:0] pz_next;
    line_t              l2_next;
    logic               en;

    assign en        = !vld_reg[LAST] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAST];
    assign out_line  = l2_reg;

    always_comb
    begin
        logic signed [32:0] ay_e;
        logic signed [32:0] by_e;
        logic signed [32:0] nd_e;
        logic a_in;
        logic b_in;
        ay_e = 33'(ay);
        by_e = 33'(by_depth);
        nd_e = $signed({2'b00, nd});
        a_in = ay_e >= nd_e;
        b_in = by_e >= nd_e;
        seg_next.ln.vis   = a_in || b_in;
        seg_next.ln.ax    = ax;
        seg_next.ln.ay    = ay;
        seg_next.ln.az    = az;
        seg_next.ln.bx    = bx;
        seg_next.ln.by    = by_depth;
        seg_next.ln.bz    = bz;
        seg_next.crossing = a_in ^ b_in;
        seg_next.a_out    = !a_in;
        seg_next.dx       = 33'(bx) - 33'(ax);
        seg_next.dz       = 33'(bz) - 33'(az);
        if (!a_in)
        begin
            num_next = {1'b0, 33'(nd_e - ay_e)};
            dvs_next = {1'b0, 33'(by_e - ay_e)};
        end
        else
        begin
            num_next = {1'b0, 33'(ay_e - nd_e)};
            dvs_next = {1'b0, 33'(ay_e - by_e)};
        end
    end

    always_comb
    begin
        logic [33:0] tmp;
        logic        ge;
        for (int s = 1; s <= DS; s++)
        begin
            tmp = (s == 1) ? rem_reg[s-1] : {rem_reg[s-1][32:0], 1'b0};
            ge  = tmp >= dvs_reg[s-1];
            rem_next[s] = ge ? tmp - dvs_reg[s-1] : tmp;
            t_next[s]   = {t_reg[s-1][TW-2:0], ge};
        end
    end

    assign px_next = seg_reg[DS].dx * $signed({1'b0, t_reg[DS]});
    assign pz_next = seg_reg[DS].dz * $signed({1'b0, t_reg[DS]});

    always_comb
    begin
        logic signed [PW-1:0] qx;
        logic signed [PW-1:0] qz;
        logic signed [31:0]   nx;
        logic signed [31:0]   nz;
        qx = (px_reg + (px_reg[PW-1] ? $signed(RND) : $signed(PW'(0)))) >>> FRAC_BITS;
        qz = (pz_reg + (pz_reg[PW-1] ? $signed(RND) : $signed(PW'(0)))) >>> FRAC_BITS;
        nx = l1_seg_reg.ln.ax + qx[31:0];
        nz = l1_seg_reg.ln.az + qz[31:0];
        l2_next = l1_seg_reg.ln;
        if (l1_seg_reg.crossing && l1_seg_reg.a_out)
        begin
            l2_next.ax = nx;
            l2_next.az = nz;
            l2_next.ay = $signed({1'b0, nd});
        end
        else if (l1_seg_reg.crossing)
        begin
            l2_next.bx = nx;
            l2_next.bz = nz;
            l2_next.by = $signed({1'b0, nd});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg[0] <= seg_next;
            rem_reg[0] <= num_next;
            dvs_reg[0] <= dvs_next;
            t_reg[0]   <= '0;
            for (int s = 1; s <= DS; s++)
            begin
                seg_reg[s] <= seg_reg[s-1];
                dvs_reg[s] <= dvs_reg[s-1];
                rem_reg[s] <= rem_next[s];
                t_reg[s]   <= t_next[s];
            end
            l1_seg_reg <= seg_reg[DS];
            px_reg     <= px_next;
            pz_reg     <= pz_next;
            l2_reg     <= l2_next;
        end
    end

endmodule

// File: hw/rtl/snc_fifo.sv
// Short queue of clipped segments between the clip front end and the projection back end.
`timescale 1ns / 1ps
module snc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  snc_pkg::line_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output snc_pkg::line_t pop_data
);
    import snc_pkg::*;

    line_t              mem_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_reg;
    logic [Q_PTR_W-1:0] rd_reg;
    logic [Q_PTR_W:0]   cnt_reg;
    logic [Q_PTR_W:0]   cnt_next;
    logic               push;
    logic               pop;

    assign push_ready = cnt_reg != (Q_PTR_W + 1)'(Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/snc_proj.sv
// Back end: perspective projection of both endpoints through four pipelined dividers.
`timescale 1ns / 1ps
module snc_proj #(
    parameter int FOCAL_LENGTH = 400
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  snc_pkg::line_t                in_line,
    input  logic [snc_pkg::SCREEN_W-1:0]  width,
    input  logic [snc_pkg::SCREEN_W-1:0]  height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          visible,
    output logic signed [15:0]            screen_ax,
    output logic signed [15:0]            screen_ay,
    output logic signed [15:0]            screen_bx,
    output logic signed [15:0]            screen_by
);
    import snc_pkg::*;

    localparam logic [13:0] F2 = 14'(2 * FOCAL_LENGTH);

    logic                 v0_reg;
    logic                 v1_reg;
    logic                 dv_reg  [0:QB];
    logic                 out_valid_reg;
    logic                 vis0_reg;
    logic                 vis1_reg;
    logic                 dvis_reg [0:QB];
    logic [31:0]          den0_reg [0:1];
    logic [31:0]          den1_reg [0:1];
    logic [31:0]          dden_reg [0:QB][0:1];
    logic signed [46:0]   mula_reg [0:LANES-1];
    logic [43:0]          mulb_reg [0:LANES-1];
    logic signed [47:0]   n_reg    [0:LANES-1];
    logic                 neg_reg  [0:QB][0:LANES-1];
    logic                 ovf_reg  [0:QB][0:LANES-1];
    logic [31:0]          rem_reg  [0:QB][0:LANES-1];
    logic [15:0]          low_reg  [0:QB][0:LANES-1];
    logic [15:0]          q_reg    [0:QB][0:LANES-1];
    logic                 vis_reg;
    logic signed [15:0]   sc_reg   [0:LANES-1];

    logic signed [46:0]   mula_next [0:LANES-1];
    logic [43:0]          mulb_next [0:LANES-1];
    logic signed [47:0]   n_next    [0:LANES-1];
    logic                 neg_next  [0:LANES-1];
    logic                 ovf_next  [0:LANES-1];
    logic [31:0]          rem0_next [0:LANES-1];
    logic [15:0]          low0_next [0:LANES-1];
    logic [31:0]          rem_next  [1:QB][0:LANES-1];
    logic [15:0]          low_next  [1:QB][0:LANES-1];
    logic [15:0]          q_next    [1:QB][0:LANES-1];
    logic signed [15:0]   sc_next   [0:LANES-1];
    logic                 en;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign visible   = vis_reg;
    assign screen_ax = sc_reg[0];
    assign screen_ay = sc_reg[1];
    assign screen_bx = sc_reg[2];
    assign screen_by = sc_reg[3];

    always_comb
    begin
        mula_next[0] = in_line.ax * $signed({1'b0, F2});
        mula_next[1] = in_line.az * $signed({1'b0, F2});
        mula_next[2] = in_line.bx * $signed({1'b0, F2});
        mula_next[3] = in_line.bz * $signed({1'b0, F2});
        mulb_next[0] = in_line.ay[30:0] * width;
        mulb_next[1] = in_line.ay[30:0] * height;
        mulb_next[2] = in_line.by[30:0] * width;
        mulb_next[3] = in_line.by[30:0] * height;
    end

    always_comb
    begin
        logic signed [47:0] b_e;
        logic [46:0]        mag;
        logic [31:0]        den;
        for (int l = 0; l < LANES; l++)
        begin
            b_e = $signed({4'b0000, mulb_reg[l]});
            n_next[l] = (l % 2 == 0) ? 48'(mula_reg[l]) + b_e : b_e - 48'(mula_reg[l]);
            den = den1_reg[l / 2];
            mag = n_reg[l][47] ? 47'(-n_reg[l]) : n_reg[l][46:0];
            neg_next[l]  = n_reg[l][47];
            ovf_next[l]  = {1'b0, mag} >= {den, 16'h0000};
            rem0_next[l] = {1'b0, mag[46:16]};
            low0_next[l] = mag[15:0];
        end
    end

    always_comb
    begin
        logic [32:0] tmp;
        logic        ge;
        for (int s = 1; s <= QB; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                tmp = {rem_reg[s-1][l], low_reg[s-1][l][15]};
                ge  = tmp >= {1'b0, dden_reg[s-1][l / 2]};
                rem_next[s][l] = ge ? 32'(tmp - {1'b0, dden_reg[s-1][l / 2]}) : tmp[31:0];
                low_next[s][l] = {low_reg[s-1][l][14:0], 1'b0};
                q_next[s][l]   = {q_reg[s-1][l][14:0], ge};
            end
        end
    end

    always_comb
    begin
        logic [15:0] q;
        for (int l = 0; l < LANES; l++)
        begin
            q = q_reg[QB][l];
            if (!dvis_reg[QB])
            begin
                sc_next[l] = '0;
            end
            else if (!neg_reg[QB][l])
            begin
                sc_next[l] = (ovf_reg[QB][l] || q[15]) ? SAT_MAX : $signed(q);
            end
            else
            begin
                sc_next[l] = (ovf_reg[QB][l] || q > 16'h8000) ? SAT_MIN : $signed(-q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= QB; s++)
            begin
                dv_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            dv_reg[0] <= v1_reg;
            for (int s = 1; s <= QB; s++)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
            out_valid_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis0_reg    <= in_line.vis;
            den0_reg[0] <= {in_line.ay[30:0], 1'b0};
            den0_reg[1] <= {in_line.by[30:0], 1'b0};
            vis1_reg    <= vis0_reg;
            den1_reg    <= den0_reg;
            dvis_reg[0] <= vis1_reg;
            dden_reg[0] <= den1_reg;
            for (int l = 0; l < LANES; l++)
            begin
                mula_reg[l]   <= mula_next[l];
                mulb_reg[l]   <= mulb_next[l];
                n_reg[l]      <= n_next[l];
                neg_reg[0][l] <= neg_next[l];
                ovf_reg[0][l] <= ovf_next[l];
                rem_reg[0][l] <= rem0_next[l];
                low_reg[0][l] <= low0_next[l];
                q_reg[0][l]   <= '0;
                sc_reg[l]     <= sc_next[l];
            end
            for (int s = 1; s <= QB; s++)
            begin
                dvis_reg[s] <= dvis_reg[s-1];
                dden_reg[s] <= dden_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                    rem_reg[s][l] <= rem_next[s][l];
                    low_reg[s][l] <= low_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                end
            end
            vis_reg <= dvis_reg[QB];
        end
    end

endmodule

// File: hw/rtl/snc_checker.sv
// Port-level checks for the segment clip and projection block, bound to the top level.
`timescale 1ns / 1ps
`include "segment_near_clip_project_core_defines.svh"
module snc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        pwrite,
    input logic [snc_pkg::ADDR_W-1:0]  paddr,
    input logic [snc_pkg::DATA_W-1:0]  prdata,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        visible,
    input logic signed [15:0]          screen_ax,
    input logic signed [15:0]          screen_ay,
    input logic signed [15:0]          screen_bx,
    input logic signed [15:0]          screen_by
);
    import snc_pkg::*;

    logic screen_zero;
    logic size_rd;

    assign screen_zero = screen_ax == 0 && screen_ay == 0 && screen_bx == 0 && screen_by == 0;
    assign size_rd     = psel && !pwrite &&
                         (paddr[3:2] == REG_SCREEN_WIDTH || paddr[3:2] == REG_SCREEN_HEIGHT);

    `SNC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SNC_ASSERT_NOW(a_hidden_zero, out_valid && !visible, screen_zero)
    `SNC_ASSERT_NOW(a_near_rd, psel && !pwrite && paddr[3:2] == REG_NEAR_DEPTH, !prdata[31])
    `SNC_ASSERT_NOW(a_size_rd, size_rd, prdata[31:13] == '0)

endmodule

bind segment_near_clip_project_core snc_checker u_snc_checker (.*);

// File: sim/tb_segment_near_clip_project_core.sv
// Testbench for the near-plane segment clip and perspective projection block.
`timescale 1ns / 1ps
module tb_segment_near_clip_project_core;
    import snc_pkg::*;

    localparam int FOCAL = 400;
    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 25;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               vis;
        logic signed [15:0] sax;
        logic signed [15:0] say;
        logic signed [15:0] sbx;
        logic signed [15:0] sby;
    } screen_line_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by_depth = '0, bz = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic visible;
    logic signed [15:0] screen_ax, screen_ay, screen_bx, screen_by;

    logic [NEAR_W-1:0] cfg_near;
    logic [SCREEN_W-1:0] cfg_width, cfg_height;
    screen_line_t expected_lines[$];
    int error_count = 0;
    int cycle_count = 0;
    int hold_off_cycles = 0;
    int sink_gap = 0;
    bit sink_idle_en = 1'b1;
    bit source_idle_en = 1'b1;

    segment_near_clip_project_core #(.FOCAL_LENGTH(FOCAL), .FRAC_BITS(FRAC)) u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .ax(ax), .ay(ay), .az(az), .bx(bx),
        .by_depth(by_depth), .bz(bz), .out_valid(out_valid), .out_ready(out_ready),
        .visible(visible), .screen_ax(screen_ax), .screen_ay(screen_ay),
        .screen_bx(screen_bx), .screen_by(screen_by)
    );

    always #5 clk = ~clk;

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint t);
        longint p;
        p = (b - a) * t;
        return a + p / (longint'(1) << FRAC);
    endfunction

    function automatic screen_line_t clip_project(input longint pax, input longint pay,
        input longint paz, input longint pbx, input longint pby, input longint pbz);
        screen_line_t r;
        longint nd, dy, num, t, one, nx, nz;
        bit a_in, b_in;
        r = '0;
        one = longint'(1) << FRAC;
        nd = (cfg_near == 0) ? 1 : longint'(cfg_near);
        a_in = pay >= nd;
        b_in = pby >= nd;
        if (!a_in && !b_in) return r;
        if (!(a_in && b_in)) begin
            dy = pby - pay;
            num = nd - pay;
            if (dy == 0) return r;
            if (dy < 0) begin
                dy = -dy;
                num = -num;
            end
            if (num < 0) t = 0;
            else begin
                t = (num * one) / dy;
                if (t > one) t = one;
            end
            nx = lerp(pax, pbx, t);
            nz = lerp(paz, pbz, t);
            if (!a_in) begin
                pax = nx; paz = nz; pay = nd;
            end
            else begin
                pbx = nx; pbz = nz; pby = nd;
            end
        end
        r.vis = 1'b1;
        r.sax = clamp16((2 * FOCAL * pax + longint'(cfg_width) * pay) / (2 * pay));
        r.say = clamp16((longint'(cfg_height) * pay - 2 * FOCAL * paz) / (2 * pay));
        r.sbx = clamp16((2 * FOCAL * pbx + longint'(cfg_width) * pby) / (2 * pby));
        r.sby = clamp16((longint'(cfg_height) * pby - 2 * FOCAL * pbz) / (2 * pby));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        screen_line_t w;
        if (rst_n && out_valid && out_ready) begin
            if (expected_lines.size() == 0) report_mismatch("unexpected beat", 0, 0);
            else begin
                w = expected_lines.pop_front();
                if (visible !== w.vis) report_mismatch("visible", visible, w.vis);
                if (screen_ax !== w.sax) report_mismatch("screen_ax", screen_ax, w.sax);
                if (screen_ay !== w.say) report_mismatch("screen_ay", screen_ay, w.say);
                if (screen_bx !== w.sbx) report_mismatch("screen_bx", screen_bx, w.sbx);
                if (screen_by !== w.sby) report_mismatch("screen_by", screen_by, w.sby);
            end
        end
    end

    always @(negedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            out_ready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else out_ready <= 1'b1;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_NEAR_DEPTH: cfg_near = value[NEAR_W-1:0];
            REG_SCREEN_WIDTH: cfg_width = value[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT: cfg_height = value[SCREEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_segment(input logic signed [31:0] pax, input logic signed [31:0] pay,
        input logic signed [31:0] paz, input logic signed [31:0] pbx,
        input logic signed [31:0] pby, input logic signed [31:0] pbz);
        int gap;
        if (source_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ax <= pax; ay <= pay; az <= paz; bx <= pbx; by_depth <= pby; bz <= pbz;
        expected_lines = {expected_lines, clip_project(pax, pay, paz, pbx, pby, pbz)};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_depth();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0040_0000);
            2: return 32'(cfg_near) + $urandom_range(0, 64) - 32;
            default: return $urandom_range(0, 32'h7fff_ffff);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_lateral();
        case ($urandom_range(0, 2))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] mx, mn, nd;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        nd = 32'(cfg_near);
        send_segment(0, nd, 0, 0, nd, 0);
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(mx, mn, mx, mn, mn, mn);
        send_segment(mx, mx, mx, mn, mx, mn);
        send_segment(mn, mx, mn, mx, mx, mx);
        send_segment(65536, nd - 1, 65536, -65536, nd + 65536, -65536);
        send_segment(65536, nd + 65536, 65536, -65536, nd - 1, -65536);
        send_segment(mx, mn, mn, mn, mx, mx);
        send_segment(mn, mx, mx, mx, mn, mn);
        send_segment(mx, nd, mx, mn, nd, mn);
        send_segment(mn, 1, mn, mx, 1, mx);
        send_segment(-1, -1, -1, -1, -1, -1);
        send_segment(1000, nd - 1, -1000, 1000, nd, -1000);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] pay, pby;
        repeat (count) begin
            pay = rand_depth();
            pby = rand_depth();
            send_segment(rand_lateral(), pay, rand_lateral(), rand_lateral(), pby,
                rand_lateral());
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 200;
        test_random(80);
    endtask

    task automatic test_config_sweep();
        write_reg(REG_NEAR_DEPTH, 32'd1);
        write_reg(REG_SCREEN_WIDTH, 32'd1);
        write_reg(REG_SCREEN_HEIGHT, 32'd4096);
        test_directed();
        test_random(150);
        wait_drain();
        write_reg(REG_NEAR_DEPTH, 32'h7fff_ffff);
        write_reg(REG_SCREEN_WIDTH, 32'd4096);
        write_reg(REG_SCREEN_HEIGHT, 32'd1);
        test_directed();
        test_random(150);
        wait_drain();
        write_reg(REG_NEAR_DEPTH, 32'd0);
        write_reg(REG_SCREEN_WIDTH, 32'h1fff);
        write_reg(REG_SCREEN_HEIGHT, 32'd0);
        test_random(100);
        wait_drain();
        write_reg(REG_NEAR_DEPTH, 32'h0001_0000);
        write_reg(REG_SCREEN_WIDTH, 32'd1920);
        write_reg(REG_SCREEN_HEIGHT, 32'd1080);
        test_random(200);
    endtask

    initial begin
        cfg_near = NEAR_RESET;
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(200);
        test_backpressure();
        wait_drain();
        test_config_sweep();
        source_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random(150);
        wait_drain();
        if (error_count == 0 && expected_lines.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: segment_near_clip_project_core.f
+incdir+hw/rtl
hw/rtl/snc_pkg.sv
hw/rtl/snc_clip.sv
hw/rtl/snc_fifo.sv
hw/rtl/snc_proj.sv
hw/rtl/segment_near_clip_project_core.sv
hw/rtl/snc_checker.sv
sim/tb_segment_near_clip_project_core.sv
